// ===== design/adsr_pkg.sv =====
// Package for the ADSR envelope scaler: port words, pipeline lane type,
// envelope phase codes and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

    // Input word: tick count and raw Q1.15 sample
    typedef struct packed {
        logic [31:0]        sample_time;
        logic signed [15:0] sample_value;
    } t_in_word;

    // Result word: shaped sample and the Q0.16 gain that produced it
    typedef struct packed {
        logic signed [14:0] shaped_sample;
        logic [15:0]        envelope_gain;
    } t_out_word;

    // Envelope phase selected for one sample
    typedef enum logic [2:0] {
        PH_ZERO,
        PH_ATTACK,
        PH_DECAY,
        PH_SUSTAIN,
        PH_RELEASE
    } t_phase;

    // Control that travels with each word through the datapath
    typedef struct packed {
        logic               valid;
        t_phase             phase;
        logic signed [15:0] sample;
    } t_lane;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_TIME     = 3'd0,
        REG_ATTACK_LENGTH  = 3'd1,
        REG_DECAY_LENGTH   = 3'd2,
        REG_RELEASE_LENGTH = 3'd3,
        REG_NOTE_DURATION  = 3'd4,
        REG_ATTACK_LEVEL   = 3'd5,
        REG_DECAY_DROP     = 3'd6
    } t_cfg_index;

    // Reset value of the attack level, cut to the level width where used
    localparam logic [31:0] RST_ATTACK_LEVEL = 32'd65535;

    // Output scale 16383 = 2^SCALE_SHIFT - 1; sample has SAMPLE_FRAC fraction bits
    localparam int unsigned SCALE_SHIFT = 14;
    localparam int unsigned SAMPLE_FRAC = 15;

endpackage

`default_nettype wire

// ===== design/adsr_phase.sv =====
// Phase decode front end: locates the sample time within the envelope and
// sets up the multiply-divide operands. Depends on adsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adsr_phase #(
    parameter int unsigned TIME_WIDTH  = 32,
    parameter int unsigned LEVEL_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [TIME_WIDTH-1:0]  i_time,
    input  wire logic signed [15:0]     i_sample,
    input  wire logic [TIME_WIDTH-1:0]  i_start_time,
    input  wire logic [TIME_WIDTH-1:0]  i_attack_len,
    input  wire logic [TIME_WIDTH-1:0]  i_decay_len,
    input  wire logic [TIME_WIDTH-1:0]  i_release_len,
    input  wire logic [TIME_WIDTH-1:0]  i_duration,
    input  wire logic [LEVEL_WIDTH-1:0] i_attack_level,
    input  wire logic [LEVEL_WIDTH-1:0] i_decay_drop,
    output adsr_pkg::t_lane             o_lane,
    output logic [TIME_WIDTH-1:0]       o_a,
    output logic [TIME_WIDTH-1:0]       o_d,
    output logic [LEVEL_WIDTH-1:0]      o_b,
    output logic [LEVEL_WIDTH-1:0]      o_held
);
    import adsr_pkg::*;

    localparam int unsigned TW = TIME_WIDTH;
    localparam int unsigned LW = LEVEL_WIDTH;

    // Sustain length and held level, derived from config: sustain through r_sus1, r_sus2, r_sus3
    logic [TW-1:0] r_sus1, r_sus2, r_sus3;
    logic [TW-1:0] n_sus1, n_sus2, n_sus3;
    logic [LW-1:0] r_held, n_held;

    assign n_sus1 = (i_duration > i_attack_len) ? i_duration - i_attack_len : '0;
    assign n_sus2 = (r_sus1 > i_decay_len) ? r_sus1 - i_decay_len : '0;
    assign n_sus3 = (r_sus2 > i_release_len) ? r_sus2 - i_release_len : '0;
    assign n_held = (i_attack_level > i_decay_drop) ? i_attack_level - i_decay_drop : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sus1 <= '0;
            r_sus2 <= '0;
            r_sus3 <= '0;
            r_held <= LW'(RST_ATTACK_LEVEL);
        end else begin
            r_sus1 <= n_sus1;
            r_sus2 <= n_sus2;
            r_sus3 <= n_sus3;
            r_held <= n_held;
        end
    end

    // Stage 1: time since note start
    logic [TW:0]          n_p1_diff;
    logic                 r_p1_vld, r_p1_before;
    logic [TW-1:0]        r_p1_dt0;
    logic signed [15:0]   r_p1_sample;

    assign n_p1_diff = {1'b0, i_time} - {1'b0, i_start_time};

    always_ff @(posedge i_clk) begin
        r_p1_before <= n_p1_diff[TW];
        r_p1_dt0    <= n_p1_diff[TW-1:0];
        r_p1_sample <= i_sample;
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_valid;
        end
    end

    // Stage 2: past the attack?
    logic [TW:0]          n_p2_diff;
    logic                 r_p2_vld, r_p2_before, r_p2_in_a;
    logic [TW-1:0]        r_p2_dt0, r_p2_dt1;
    logic signed [15:0]   r_p2_sample;

    assign n_p2_diff = {1'b0, r_p1_dt0} - {1'b0, i_attack_len};

    always_ff @(posedge i_clk) begin
        r_p2_before <= r_p1_before;
        r_p2_in_a   <= n_p2_diff[TW];
        r_p2_dt0    <= r_p1_dt0;
        r_p2_dt1    <= n_p2_diff[TW-1:0];
        r_p2_sample <= r_p1_sample;
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else begin
            r_p2_vld <= r_p1_vld;
        end
    end

    // Stage 3: past the decay?
    logic [TW:0]          n_p3_diff;
    logic                 r_p3_vld, r_p3_before, r_p3_in_a, r_p3_in_d;
    logic [TW-1:0]        r_p3_dt0, r_p3_dt1, r_p3_dt2;
    logic signed [15:0]   r_p3_sample;

    assign n_p3_diff = {1'b0, r_p2_dt1} - {1'b0, i_decay_len};

    always_ff @(posedge i_clk) begin
        r_p3_before <= r_p2_before;
        r_p3_in_a   <= r_p2_in_a;
        r_p3_in_d   <= n_p3_diff[TW];
        r_p3_dt0    <= r_p2_dt0;
        r_p3_dt1    <= r_p2_dt1;
        r_p3_dt2    <= n_p3_diff[TW-1:0];
        r_p3_sample <= r_p2_sample;
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else begin
            r_p3_vld <= r_p2_vld;
        end
    end

    // Stage 4: past the sustain?
    logic [TW:0]          n_p4_diff;
    logic                 r_p4_vld, r_p4_before, r_p4_in_a, r_p4_in_d, r_p4_in_s;
    logic [TW-1:0]        r_p4_dt0, r_p4_dt1, r_p4_dt3;
    logic signed [15:0]   r_p4_sample;

    assign n_p4_diff = {1'b0, r_p3_dt2} - {1'b0, r_sus3};

    always_ff @(posedge i_clk) begin
        r_p4_before <= r_p3_before;
        r_p4_in_a   <= r_p3_in_a;
        r_p4_in_d   <= r_p3_in_d;
        r_p4_in_s   <= n_p4_diff[TW];
        r_p4_dt0    <= r_p3_dt0;
        r_p4_dt1    <= r_p3_dt1;
        r_p4_dt3    <= n_p4_diff[TW-1:0];
        r_p4_sample <= r_p3_sample;
        if (!i_rst_n) begin
            r_p4_vld <= 1'b0;
        end else begin
            r_p4_vld <= r_p3_vld;
        end
    end

    // Stage 5: release remainder, then phase and operand select
    logic [TW:0]   n_p5_diff;
    logic          n_p5_in_r;
    t_phase        n_p5_phase;
    logic [TW-1:0] n_p5_a, n_p5_d;
    logic [LW-1:0] n_p5_b;

    assign n_p5_diff = {1'b0, i_release_len} - {1'b0, r_p4_dt3};
    assign n_p5_in_r = !n_p5_diff[TW] && (n_p5_diff[TW-1:0] != '0);

    always_comb begin
        n_p5_phase = PH_ZERO;
        n_p5_a     = '0;
        n_p5_b     = '0;
        n_p5_d     = '0;
        if (!r_p4_before) begin
            if (r_p4_in_a) begin
                n_p5_phase = PH_ATTACK;
                n_p5_a     = r_p4_dt0;
                n_p5_b     = i_attack_level;
                n_p5_d     = i_attack_len;
            end else if (r_p4_in_d) begin
                n_p5_phase = PH_DECAY;
                n_p5_a     = r_p4_dt1;
                n_p5_b     = i_decay_drop;
                n_p5_d     = i_decay_len;
            end else if (r_p4_in_s) begin
                n_p5_phase = PH_SUSTAIN;
            end else if (n_p5_in_r) begin
                n_p5_phase = PH_RELEASE;
                n_p5_a     = n_p5_diff[TW-1:0];
                n_p5_b     = r_held;
                n_p5_d     = i_release_len;
            end
        end
    end

    t_lane         r_p5_lane;
    logic [TW-1:0] r_p5_a, r_p5_d;
    logic [LW-1:0] r_p5_b;

    always_ff @(posedge i_clk) begin
        r_p5_lane.phase  <= n_p5_phase;
        r_p5_lane.sample <= r_p4_sample;
        r_p5_a           <= n_p5_a;
        r_p5_b           <= n_p5_b;
        r_p5_d           <= n_p5_d;
        if (!i_rst_n) begin
            r_p5_lane.valid <= 1'b0;
        end else begin
            r_p5_lane.valid <= r_p4_vld;
        end
    end

    assign o_lane = r_p5_lane;
    assign o_a    = r_p5_a;
    assign o_d    = r_p5_d;
    assign o_b    = r_p5_b;
    assign o_held = r_held;

    // Divide operands must keep the numerator below divisor * 2^LW
    a_attack_operands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p5_lane.valid && r_p5_lane.phase == PH_ATTACK |-> r_p5_a < r_p5_d)
        else $error("attack offset not below attack length");

    a_release_operands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p5_lane.valid && r_p5_lane.phase == PH_RELEASE
        |-> r_p5_a != '0 && r_p5_a <= r_p5_d)
        else $error("release remainder out of range");

endmodule

`default_nettype wire

// ===== design/adsr_div_stage.sv =====
// One stage of the pipelined multiply-divide floor(a*b/d): takes one bit
// of b, MSB first, keeping remainder below d. Depends on adsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adsr_div_stage #(
    parameter int unsigned TIME_WIDTH  = 32,
    parameter int unsigned LEVEL_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire adsr_pkg::t_lane        i_lane,
    input  wire logic [TIME_WIDTH-1:0]  i_a,
    input  wire logic [TIME_WIDTH-1:0]  i_d,
    input  wire logic [LEVEL_WIDTH-1:0] i_b,
    input  wire logic [TIME_WIDTH-1:0]  i_r,
    input  wire logic [LEVEL_WIDTH-1:0] i_q,
    output adsr_pkg::t_lane             o_lane,
    output logic [TIME_WIDTH-1:0]       o_a,
    output logic [TIME_WIDTH-1:0]       o_d,
    output logic [LEVEL_WIDTH-1:0]      o_b,
    output logic [TIME_WIDTH-1:0]       o_r,
    output logic [LEVEL_WIDTH-1:0]      o_q
);
    import adsr_pkg::*;

    localparam int unsigned TW = TIME_WIDTH;
    localparam int unsigned LW = LEVEL_WIDTH;

    // Doubling: 2r mod d, quotient digit into the new LSB
    logic [TW-1:0] n_d_minus_r, n_r_dbl, n_d_minus_a, n_r;
    logic          n_dbl_ge, n_add_ge, n_bit;
    logic [LW-1:0] n_q_dbl, n_q, n_b;

    assign n_d_minus_r = i_d - i_r;
    assign n_dbl_ge    = i_r >= n_d_minus_r;
    assign n_r_dbl     = n_dbl_ge ? i_r - n_d_minus_r : i_r + i_r;
    assign n_q_dbl     = {i_q[LW-2:0], n_dbl_ge};

    // Conditional add of a mod d when this bit of b is set
    assign n_bit       = i_b[LW-1];
    assign n_d_minus_a = i_d - i_a;
    assign n_add_ge    = n_bit && (n_r_dbl >= n_d_minus_a);
    assign n_r         = !n_bit   ? n_r_dbl :
                         n_add_ge ? n_r_dbl - n_d_minus_a : n_r_dbl + i_a;
    assign n_q         = n_q_dbl + LW'(n_add_ge);
    assign n_b         = {i_b[LW-2:0], 1'b0};

    t_lane         r_lane;
    logic [TW-1:0] r_a, r_d, r_r;
    logic [LW-1:0] r_b, r_q;

    always_ff @(posedge i_clk) begin
        r_lane.phase  <= i_lane.phase;
        r_lane.sample <= i_lane.sample;
        r_a           <= i_a;
        r_d           <= i_d;
        r_b           <= n_b;
        r_r           <= n_r;
        r_q           <= n_q;
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else begin
            r_lane.valid <= i_lane.valid;
        end
    end

    assign o_lane = r_lane;
    assign o_a    = r_a;
    assign o_d    = r_d;
    assign o_b    = r_b;
    assign o_r    = r_r;
    assign o_q    = r_q;

    // Remainder stays reduced modulo the divisor in the dividing phases
    a_rem_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lane.valid && (r_lane.phase == PH_ATTACK || r_lane.phase == PH_DECAY ||
                         r_lane.phase == PH_RELEASE)
        |-> r_r < r_d)
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// ===== design/adsr_scale.sv =====
// Back end: gain select from the quotient or held level, then sample * gain * 16383
// truncated toward zero, over three stages. Depends on adsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adsr_scale #(
    parameter int unsigned TIME_WIDTH  = 32,
    parameter int unsigned LEVEL_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire adsr_pkg::t_lane        i_lane,
    input  wire logic [LEVEL_WIDTH-1:0] i_q,
    input  wire logic [TIME_WIDTH-1:0]  i_r,
    input  wire logic [LEVEL_WIDTH-1:0] i_attack_level,
    input  wire logic [LEVEL_WIDTH-1:0] i_held,
    output logic                        o_valid,
    output adsr_pkg::t_out_word         o_result
);
    import adsr_pkg::*;

    localparam int unsigned LW  = LEVEL_WIDTH;
    localparam int unsigned MW  = LW + 16;
    localparam int unsigned PW  = MW + SCALE_SHIFT;
    localparam int unsigned SHR = LW + SAMPLE_FRAC;

    // Stage 1: gain; decay rounds the drop up and clamps at zero
    logic          n_rem_nz;
    logic [LW:0]   n_qc, n_dec_diff;
    logic [LW-1:0] n_gain;

    assign n_rem_nz   = i_r != '0;
    assign n_qc       = {1'b0, i_q} + (LW+1)'(n_rem_nz);
    assign n_dec_diff = {1'b0, i_attack_level} - n_qc;

    always_comb begin
        case (i_lane.phase)
            PH_ATTACK, PH_RELEASE: n_gain = i_q;
            PH_DECAY:              n_gain = n_dec_diff[LW] ? '0 : n_dec_diff[LW-1:0];
            PH_SUSTAIN:            n_gain = i_held;
            default:               n_gain = '0;
        endcase
    end

    logic               r_s1_vld;
    logic [LW-1:0]      r_s1_gain;
    logic signed [15:0] r_s1_sample;

    always_ff @(posedge i_clk) begin
        r_s1_gain   <= n_gain;
        r_s1_sample <= i_lane.sample;
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_lane.valid;
        end
    end

    // Stage 2: gain * |sample|
    logic          n_neg;
    logic [15:0]   n_raw, n_mag;
    logic [MW-1:0] n_m;

    assign n_neg = r_s1_sample[15];
    assign n_raw = r_s1_sample;
    assign n_mag = n_neg ? (~n_raw + 16'd1) : n_raw;
    assign n_m   = MW'(r_s1_gain) * MW'(n_mag);

    logic          r_s2_vld, r_s2_neg;
    logic [MW-1:0] r_s2_m;
    logic [LW-1:0] r_s2_gain;

    always_ff @(posedge i_clk) begin
        r_s2_neg  <= n_neg;
        r_s2_m    <= n_m;
        r_s2_gain <= r_s1_gain;
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    // Stage 3: times 16383 by shift and subtract, drop fraction, restore sign
    logic [PW-1:0] n_p;
    logic [14:0]   n_prod, n_shaped;

    assign n_p      = {r_s2_m, SCALE_SHIFT'(0)} - PW'(r_s2_m);
    assign n_prod   = 15'(n_p >> SHR);
    assign n_shaped = r_s2_neg ? (15'd0 - n_prod) : n_prod;

    logic      r_o_vld;
    t_out_word r_o;

    always_ff @(posedge i_clk) begin
        r_o.shaped_sample <= n_shaped;
        r_o.envelope_gain <= 16'(r_s2_gain);
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_s2_vld;
        end
    end

    assign o_valid  = r_o_vld;
    assign o_result = r_o;

    // Zero gain must give a silent sample
    a_zero_gain_silent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld && r_s2_gain == '0 |=> r_o_vld && r_o.shaped_sample == '0)
        else $error("nonzero output with zero gain");

    // A non-negative sample never turns negative
    a_sign_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld && !r_s2_neg |=> !r_o.shaped_sample[14])
        else $error("sign flipped on positive sample");

endmodule

`default_nettype wire

// ===== design/adsr_envelope_scaler.sv =====
// Top level of the ADSR envelope scaler: configuration registers, phase
// front end, multiply-divide pipeline and output scaling.
// Throughput: one word per cycle; busy never rises, set by the pipelined
// multiply-divide that resolves one quotient bit per stage.
// Reset clears all valid bits and loads config reset values; no clearing pass.
// The result strobe lasts one cycle; the receiver cannot stall.
// Depends on adsr_pkg, adsr_phase, adsr_div_stage, adsr_scale.
`timescale 1ns / 1ps
`default_nettype none

module adsr_envelope_scaler #(
    parameter int unsigned TIME_WIDTH  = 32,
    parameter int unsigned LEVEL_WIDTH = 16,
    localparam int unsigned CFG_WIDTH  = (TIME_WIDTH > LEVEL_WIDTH) ? TIME_WIDTH : LEVEL_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire adsr_pkg::t_in_word                i_cmd,
    output logic                                   o_result_valid,
    output adsr_pkg::t_out_word                    o_result,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [adsr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_WIDTH-1:0]              i_cfg_data
);
    import adsr_pkg::*;

    localparam int unsigned TW = TIME_WIDTH;
    localparam int unsigned LW = LEVEL_WIDTH;

    // Pipeline never stalls
    logic accept;
    assign busy        = 1'b0;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    logic [TW-1:0] r_start_time, r_attack_len, r_decay_len, r_release_len, r_duration;
    logic [LW-1:0] r_attack_level, r_decay_drop;
    logic          cfg_we;

    assign cfg_we = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time   <= '0;
            r_attack_len   <= '0;
            r_decay_len    <= '0;
            r_release_len  <= '0;
            r_duration     <= '0;
            r_attack_level <= LW'(RST_ATTACK_LEVEL);
            r_decay_drop   <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_START_TIME:     r_start_time   <= i_cfg_data[TW-1:0];
                REG_ATTACK_LENGTH:  r_attack_len   <= i_cfg_data[TW-1:0];
                REG_DECAY_LENGTH:   r_decay_len    <= i_cfg_data[TW-1:0];
                REG_RELEASE_LENGTH: r_release_len  <= i_cfg_data[TW-1:0];
                REG_NOTE_DURATION:  r_duration     <= i_cfg_data[TW-1:0];
                REG_ATTACK_LEVEL:   r_attack_level <= i_cfg_data[LW-1:0];
                REG_DECAY_DROP:     r_decay_drop   <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Front end: phase decode and divide operands
    t_lane         div_lane [LW+1];
    logic [TW-1:0] div_a    [LW+1];
    logic [TW-1:0] div_d    [LW+1];
    logic [LW-1:0] div_b    [LW+1];
    logic [TW-1:0] div_r    [LW+1];
    logic [LW-1:0] div_q    [LW+1];
    logic [LW-1:0] held;

    adsr_phase #(
        .TIME_WIDTH  (TW),
        .LEVEL_WIDTH (LW)
    ) u_phase (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_time         (TW'(i_cmd.sample_time)),
        .i_sample       (i_cmd.sample_value),
        .i_start_time   (r_start_time),
        .i_attack_len   (r_attack_len),
        .i_decay_len    (r_decay_len),
        .i_release_len  (r_release_len),
        .i_duration     (r_duration),
        .i_attack_level (r_attack_level),
        .i_decay_drop   (r_decay_drop),
        .o_lane         (div_lane[0]),
        .o_a            (div_a[0]),
        .o_d            (div_d[0]),
        .o_b            (div_b[0]),
        .o_held         (held)
    );

    assign div_r[0] = '0;
    assign div_q[0] = '0;

    // Multiply-divide: one quotient bit per stage
    for (genvar g = 0; g < LW; g++) begin : g_div
        adsr_div_stage #(
            .TIME_WIDTH  (TW),
            .LEVEL_WIDTH (LW)
        ) u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lane  (div_lane[g]),
            .i_a     (div_a[g]),
            .i_d     (div_d[g]),
            .i_b     (div_b[g]),
            .i_r     (div_r[g]),
            .i_q     (div_q[g]),
            .o_lane  (div_lane[g+1]),
            .o_a     (div_a[g+1]),
            .o_d     (div_d[g+1]),
            .o_b     (div_b[g+1]),
            .o_r     (div_r[g+1]),
            .o_q     (div_q[g+1])
        );
    end

    // Back end: gain and scaled sample
    adsr_scale #(
        .TIME_WIDTH  (TW),
        .LEVEL_WIDTH (LW)
    ) u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_lane         (div_lane[LW]),
        .i_q            (div_q[LW]),
        .i_r            (div_r[LW]),
        .i_attack_level (r_attack_level),
        .i_held         (held),
        .o_valid        (o_result_valid),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for adsr_envelope_scaler: directed and random envelope settings,
// with every result checked against a built-in gain and shaping predictor.
// Depends on adsr_pkg and adsr_envelope_scaler.
`timescale 1ns / 1ps

module tb;
    import adsr_pkg::*;

    // Local copy of the envelope register file
    typedef struct {
        bit [31:0] start_tick;
        bit [31:0] attack_ticks;
        bit [31:0] decay_ticks;
        bit [31:0] release_ticks;
        bit [31:0] duration_ticks;
        bit [15:0] peak_level;
        bit [15:0] drop_level;
    } t_envelope;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_in_word   i_cmd = '0;
    logic       o_result_valid;
    t_out_word  o_result;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_index i_cfg_index = REG_START_TIME;
    logic [31:0] i_cfg_data = '0;

    t_envelope  live_env;
    t_out_word  shaped_q[$];
    int         mismatch_count = 0;
    int         idle_pct = 0;

    adsr_envelope_scaler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Sustain length; each subtraction saturates at zero
    function automatic longint unsigned sustain_ticks(t_envelope e);
        longint unsigned s;
        s = (e.duration_ticks > e.attack_ticks) ? e.duration_ticks - e.attack_ticks : 0;
        s = (s > e.decay_ticks) ? s - e.decay_ticks : 0;
        s = (s > e.release_ticks) ? s - e.release_ticks : 0;
        return s;
    endfunction

    // Q0.16 gain at a tick, floor of the exact piecewise-linear value
    function automatic bit [15:0] gain_at(t_envelope e, bit [31:0] tick);
        longint unsigned dt, held, sus, num, q;
        if (tick < e.start_tick)
            return 16'd0;
        dt = tick - e.start_tick;
        if (dt < e.attack_ticks)
            return 16'((dt * e.peak_level) / e.attack_ticks);
        dt -= e.attack_ticks;
        if (dt < e.decay_ticks) begin
            // drop rounded up so the gain is floored
            num = dt * e.drop_level;
            q = num / e.decay_ticks + ((num % e.decay_ticks) != 0);
            return (e.peak_level > q) ? 16'(e.peak_level - q) : 16'd0;
        end
        dt -= e.decay_ticks;
        held = (e.peak_level > e.drop_level) ? e.peak_level - e.drop_level : 0;
        sus = sustain_ticks(e);
        if (dt < sus)
            return 16'(held);
        dt -= sus;
        if (dt < e.release_ticks)
            return 16'(((e.release_ticks - dt) * held) / e.release_ticks);
        return 16'd0;
    endfunction

    // Expected result word: sign-magnitude scaling, truncated toward zero
    function automatic t_out_word shape_sample(t_envelope e, t_in_word w);
        longint unsigned gain, mag, prod;
        bit [15:0] raw;
        t_out_word r;
        raw = w.sample_value;
        gain = gain_at(e, w.sample_time);
        mag = raw[15] ? 64'd65536 - raw : raw;
        prod = (gain * ((64'd1 << SCALE_SHIFT) - 1) * mag) >> (16 + SAMPLE_FRAC);
        r.envelope_gain = gain[15:0];
        r.shaped_sample = raw[15] ? 15'(-prod) : 15'(prod);
        return r;
    endfunction

    // Track config writes, predict accepted words, check result words
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            live_env = '{0, 0, 0, 0, 0, RST_ATTACK_LEVEL[15:0], 16'd0};
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_START_TIME:     live_env.start_tick = i_cfg_data;
                    REG_ATTACK_LENGTH:  live_env.attack_ticks = i_cfg_data;
                    REG_DECAY_LENGTH:   live_env.decay_ticks = i_cfg_data;
                    REG_RELEASE_LENGTH: live_env.release_ticks = i_cfg_data;
                    REG_NOTE_DURATION:  live_env.duration_ticks = i_cfg_data;
                    REG_ATTACK_LEVEL:   live_env.peak_level = i_cfg_data[15:0];
                    REG_DECAY_DROP:     live_env.drop_level = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (o_result_valid) begin
                if (shaped_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result word with none expected, actual %0d/%0d",
                             $time, o_result.shaped_sample, o_result.envelope_gain);
                end else begin
                    want = shaped_q.pop_front();
                    if (o_result.shaped_sample !== want.shaped_sample) begin
                        mismatch_count++;
                        $display("%0t: shaped_sample expected %0d actual %0d",
                                 $time, want.shaped_sample, o_result.shaped_sample);
                    end
                    if (o_result.envelope_gain !== want.envelope_gain) begin
                        mismatch_count++;
                        $display("%0t: envelope_gain expected %0d actual %0d",
                                 $time, want.envelope_gain, o_result.envelope_gain);
                    end
                end
            end
            if (start && !busy)
                shaped_q.push_back(shape_sample(live_env, i_cmd));
        end
    end

    // Send one word, with random idle cycles ahead of it
    task automatic send_sample(bit [31:0] tick, bit [15:0] value);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= '{sample_time: tick, sample_value: value};
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Stop sending and wait until every expected word has come back
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (shaped_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, bit [31:0] value);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Program all seven registers once the block is idle
    task automatic load_envelope(t_envelope e);
        settle();
        write_reg(REG_START_TIME, e.start_tick);
        write_reg(REG_ATTACK_LENGTH, e.attack_ticks);
        write_reg(REG_DECAY_LENGTH, e.decay_ticks);
        write_reg(REG_RELEASE_LENGTH, e.release_ticks);
        write_reg(REG_NOTE_DURATION, e.duration_ticks);
        // upper data bits are don't-care for the level registers
        write_reg(REG_ATTACK_LEVEL, {16'($urandom), e.peak_level});
        write_reg(REG_DECAY_DROP, {16'($urandom), e.drop_level});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic bit [31:0] short_len();
        return ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom_range(1, 400));
    endfunction

    // Random note setting; first two of each batch are the extremes
    function automatic t_envelope roll_envelope(int note);
        t_envelope e;
        longint signed total;
        case (note)
            0: e = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF};
            1: e = '{0, 0, 0, 0, 0, 16'd0, 16'd0};
            default: begin
                if ($urandom_range(5) == 0) begin
                    e = '{$urandom, $urandom, $urandom, $urandom, $urandom,
                          16'($urandom), 16'($urandom)};
                end else begin
                    e.start_tick = ($urandom_range(3) == 0) ?
                                   32'hFFFF_FFFF - $urandom_range(300) : $urandom_range(2000);
                    e.attack_ticks = short_len();
                    e.decay_ticks = short_len();
                    e.release_ticks = short_len();
                    // duration may fall short of the phases (no sustain)
                    total = longint'(e.attack_ticks) + e.decay_ticks + e.release_ticks
                            + $urandom_range(200) - 80;
                    e.duration_ticks = (total < 0) ? 32'd0 : 32'(total);
                    e.peak_level = 16'($urandom);
                    e.drop_level = ($urandom_range(3) == 0) ? 16'($urandom) :
                                   16'($urandom_range(0, e.peak_level));
                end
            end
        endcase
        return e;
    endfunction

    // Tick near a phase boundary or inside a phase, sometimes anywhere
    function automatic bit [31:0] pick_tick(t_envelope e);
        longint unsigned mark [5];
        int k;
        mark[0] = e.start_tick;
        mark[1] = mark[0] + e.attack_ticks;
        mark[2] = mark[1] + e.decay_ticks;
        mark[3] = mark[2] + sustain_ticks(e);
        mark[4] = mark[3] + e.release_ticks;
        case ($urandom_range(3))
            0: return $urandom;
            1: begin
                k = $urandom_range(4);
                return 32'(mark[k] + $urandom_range(8) - 4);
            end
            default: begin
                k = $urandom_range(3);
                return 32'(mark[k] + ({32'd0, $urandom} % (mark[k+1] - mark[k] + 1)));
            end
        endcase
    endfunction

    function automatic bit [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Reset settings: no phases, so the gain is always zero
    task automatic test_reset_defaults();
        send_sample(32'd0, 16'h7FFF);
        send_sample(32'hFFFF_FFFF, 16'h8000);
    endtask

    // Walk every phase boundary of one ordinary note
    task automatic test_phase_walk();
        load_envelope('{100, 50, 40, 60, 300, 16'hFFFF, 16'd20000});
        send_sample(32'd99, 16'h7FFF);
        send_sample(32'd100, 16'h7FFF);
        send_sample(32'd125, 16'h8000);
        send_sample(32'd149, 16'h7FFF);
        send_sample(32'd150, 16'h8000);
        send_sample(32'd170, 16'h0001);
        send_sample(32'd189, 16'hFFFF);
        send_sample(32'd190, 16'h7FFF);
        send_sample(32'd339, 16'h8000);
        send_sample(32'd340, 16'h4000);
        send_sample(32'd370, 16'hC000);
        send_sample(32'd399, 16'h7FFF);
        send_sample(32'd400, 16'h7FFF);
        send_sample(32'hFFFF_FFFF, 16'h0000);
    endtask

    task automatic test_special_cases();
        // drop above level with zero attack and release, no sustain
        load_envelope('{10, 0, 30, 0, 5, 16'd1000, 16'd40000});
        send_sample(32'd10, 16'h7FFF);
        send_sample(32'd11, 16'h7FFF);
        send_sample(32'd39, 16'h8000);
        send_sample(32'd40, 16'h7FFF);
        // zero decay, duration shorter than the phases
        load_envelope('{0, 20, 0, 30, 10, 16'd40000, 16'd5000});
        send_sample(32'd19, 16'h7FFF);
        send_sample(32'd20, 16'h8000);
        send_sample(32'd35, 16'h7FFF);
        send_sample(32'd50, 16'h7FFF);
        // widest attack with full level and the most negative sample
        load_envelope('{0, 32'hFFFF_FFFF, 0, 0, 0, 16'hFFFF, 16'd0});
        send_sample(32'hFFFF_FFFE, 16'h8000);
    endtask

    task automatic test_random_notes(int idle, int words);
        t_envelope e;
        idle_pct = idle;
        for (int note = 0; note < words / 50; note++) begin
            e = roll_envelope(note);
            load_envelope(e);
            repeat (50)
                send_sample(pick_tick(e), pick_sample());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_phase_walk();
        test_special_cases();
        test_random_notes(24, 650);
        test_random_notes(59, 650);
        test_random_notes(0, 650);
        settle();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("adsr_envelope_scaler regression: pass");
        else
            $display("adsr_envelope_scaler regression: fail");
        $finish;
    end

    // Run limit
    initial begin
        #3_000_000;
        $display("adsr_envelope_scaler regression: fail");
        $finish;
    end

endmodule

// ===== adsr_envelope_scaler.f =====
design/adsr_pkg.sv
design/adsr_phase.sv
design/adsr_div_stage.sv
design/adsr_scale.sv
design/adsr_envelope_scaler.sv
tb/tb.sv
